@@ rtl/aet_pkg.sv @@
package aet_pkg;

    localparam int OutputBytesDefault = 8;

    typedef struct packed {
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] plaintext_hi;
        logic [63:0] plaintext_lo;
    } in_item_t;

    typedef struct packed {
        logic [63:0] witness_word;
        logic [3:0]  witness_bytes;
        logic [63:0] cipher_hi;
        logic [63:0] cipher_lo;
        logic        last;
    } out_item_t;

    // Job handed from the front end to the cipher engine.
    typedef struct packed {
        logic [255:0] key;
        logic [127:0] pt;
        logic         aes256;
    } job_t;

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ p;
            p = xt(p);
        end
        gmul = r;
    endfunction

    // Inverse table, built as a constant function (x^254).
    function automatic logic [7:0] ginv_calc(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = x;
        for (int i = 0; i < 8; i++)
        begin
            if (i != 0)
                r = gmul(r, p);
            p = gmul(p, p);
        end
        ginv_calc = r;
    endfunction

    typedef logic [7:0] byte_tab_t [256];

    function automatic byte_tab_t make_inv();
        byte_tab_t t;
        for (int i = 0; i < 256; i++)
            t[i] = ginv_calc(8'(i));
        make_inv = t;
    endfunction

    localparam byte_tab_t InvTab = make_inv();

    // Affine transform applied after the inverse.
    function automatic logic [7:0] affine(input logic [7:0] t);
        logic [7:0] rows [8];
        logic [7:0] res;
        rows = '{8'hF1, 8'hE3, 8'hC7, 8'h8F, 8'h1F, 8'h3E, 8'h7C, 8'hF8};
        for (int i = 0; i < 8; i++)
            res[i] = ^(rows[i] & t);
        affine = res ^ 8'h63;
    endfunction

endpackage

@@ rtl/aes_encrypt_inverse_trace.sv @@
// Channel   | Handshake            | Payload
// input     | push / full          | in_item  (aet_pkg::in_item_t)
// result    | pop / empty          | out_item (aet_pkg::out_item_t)
// config    | cfg_we               | cfg_data (key_size)
// A block runs key streaming, key expansion and the rounds; expansion and the
// rounds use the one shared S-box, one byte per cycle while the result queue
// does not stall the engine.
// A two-entry job queue lets the next block be accepted while one is in work.
// The engine stalls when the four-entry result queue is nearly full.
// Reset is asynchronous and clears all control state and key_size.
module aes_encrypt_inverse_trace #(
    parameter int OUTPUT_BYTES = aet_pkg::OutputBytesDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               push,
    output logic               full,
    input  aet_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output aet_pkg::out_item_t out_item
);
    import aet_pkg::*;

    logic job_valid, job_take;
    job_t job;

    aet_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .push(push), .full(full), .in_item(in_item),
        .job_valid(job_valid), .job_take(job_take), .job(job)
    );

    aet_back #(.OUTPUT_BYTES(OUTPUT_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
        .job(job), .empty(empty), .pop(pop), .out_item(out_item)
    );
endmodule

@@ rtl/aet_front.sv @@
module aet_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_data,
    input  logic            push,
    output logic            full,
    input  aet_pkg::in_item_t in_item,
    output logic            job_valid,
    input  logic            job_take,
    output aet_pkg::job_t   job
);
    import aet_pkg::*;

    logic  key_size_reg;
    logic  [1:0] cnt_reg;
    job_t  q_reg [2];
    logic  wp_reg, rp_reg;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_size_reg <= 1'b0;
        else if (cfg_we)
            key_size_reg <= cfg_data;
    end

    assign full = cnt_reg[1];
    assign job_valid = cnt_reg != 2'd0;
    assign job = q_reg[rp_reg];

    // Two-entry job queue; AES-128 jobs get key words 2 and 3 zeroed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (job_take && job_valid)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, job_take && job_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            q_reg[wp_reg].key <= {in_item.key_word0, in_item.key_word1,
                key_size_reg ? in_item.key_word2 : 64'd0,
                key_size_reg ? in_item.key_word3 : 64'd0};
            q_reg[wp_reg].pt <= {in_item.plaintext_hi, in_item.plaintext_lo};
            q_reg[wp_reg].aes256 <= key_size_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("job queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !job_take) |=> full)
        else $error("full dropped without a take");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!job_valid && !push) |=> !job_valid)
        else $error("job appeared from nowhere");
endmodule

@@ rtl/aet_back.sv @@
module aet_back #(
    parameter int OUTPUT_BYTES = aet_pkg::OutputBytesDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_take,
    input  aet_pkg::job_t    job,
    output logic             empty,
    input  logic             pop,
    output aet_pkg::out_item_t out_item
);
    import aet_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_KEY  = 5'b00010,
        S_SCH  = 5'b00100,
        S_RND  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    localparam int FillW = $clog2(OUTPUT_BYTES + 1);

    state_t       state_reg;
    logic [255:0] kwin_reg;      // key window: last Nk words, word 0 oldest
    logic [127:0] st_reg;
    logic [255:0] kin_reg;       // key bytes still to stream
    logic [5:0]   kleft_reg;
    logic [5:0]   wi_reg;        // schedule word index
    logic [1:0]   sb_reg;        // byte in SubWord
    logic [31:0]  tw_reg;        // SubWord result under construction
    logic [3:0]   rnd_reg;
    logic [3:0]   kb_reg;        // byte in SubBytes
    logic [7:0]   rc_reg;
    logic         aes256_reg;
    logic [127:0] rkeys_reg [15];
    logic [63:0]  pb_reg;
    logic [FillW-1:0] pf_reg;
    logic [127:0] ct_reg;
    out_item_t    oq_reg [4];
    logic [2:0]   ocnt_reg;
    logic [1:0]   owp_reg, orp_reg;

    logic [7:0]   byte_in, inv_b, sb_out, wb;
    logic         wb_valid, emit_last, stall;
    logic [31:0]  prev_w, old_w, new_w;
    logic [5:0]   total;
    logic [3:0]   nr;
    logic [1:0]   rot_sel;
    logic [127:0] sub_st, sr_st, mc_st, rk;

    assign nr = aes256_reg ? 4'd14 : 4'd10;
    assign total = aes256_reg ? 6'd60 : 6'd44;
    assign prev_w = aes256_reg ? kwin_reg[31:0] : kwin_reg[159:128];
    assign old_w = kwin_reg[255:224];
    assign rot_sel = sb_reg + 2'd1;

    // S-box input selection for the single shared S-box.
    always_comb
    begin
        if (state_reg == S_SCH)
        begin
            if (wi_reg[2:0] == 3'd0 || (!aes256_reg && wi_reg[1:0] == 2'd0))
                byte_in = prev_w[8'(31 - 8 * 32'(rot_sel)) -: 8];
            else
                byte_in = prev_w[8'(31 - 8 * 32'(sb_reg)) -: 8];
        end
        else
            byte_in = st_reg[8'(127 - 8 * 32'(kb_reg)) -: 8];
    end
    assign inv_b = InvTab[byte_in];
    assign sb_out = affine(inv_b);

    // Round data path for the completed SubBytes state.
    always_comb
    begin
        logic [7:0] a [16];
        logic [7:0] s [16];
        for (int k = 0; k < 16; k++)
            a[k] = st_reg[127 - 8 * k -: 8];
        a[15] = sb_out;
        for (int k = 0; k < 16; k++)
            s[k] = a[(k & 3) + 4 * (((k >> 2) + (k & 3)) & 3)];
        for (int k = 0; k < 16; k++)
            sr_st[127 - 8 * k -: 8] = s[k];
        for (int c = 0; c < 4; c++)
        begin
            mc_st[127 - 32 * c -: 8] = xt(s[4*c]) ^ xt(s[4*c+1]) ^ s[4*c+1]
                ^ s[4*c+2] ^ s[4*c+3];
            mc_st[119 - 32 * c -: 8] = s[4*c] ^ xt(s[4*c+1]) ^ xt(s[4*c+2])
                ^ s[4*c+2] ^ s[4*c+3];
            mc_st[111 - 32 * c -: 8] = s[4*c] ^ s[4*c+1] ^ xt(s[4*c+2])
                ^ xt(s[4*c+3]) ^ s[4*c+3];
            mc_st[103 - 32 * c -: 8] = xt(s[4*c]) ^ s[4*c] ^ s[4*c+1]
                ^ s[4*c+2] ^ xt(s[4*c+3]);
        end
        sub_st = st_reg;
        sub_st[8'(127 - 8 * 32'(kb_reg)) -: 8] = sb_out;
    end
    assign rk = rkeys_reg[rnd_reg];

    // Witness byte produced this cycle.
    always_comb
    begin
        wb_valid = 1'b0;
        wb = 8'h00;
        if (state_reg == S_KEY)
        begin
            wb_valid = 1'b1;
            wb = kin_reg[255:248];
        end
        else if (state_reg == S_RND ||
                 (state_reg == S_SCH && (wi_reg[2:0] == 3'd0 || wi_reg[1:0] == 2'd0)))
        begin
            wb_valid = 1'b1;
            wb = inv_b;
        end
    end
    assign emit_last = state_reg == S_FIN;
    assign stall = ocnt_reg > 3'd2;
    assign job_take = state_reg == S_IDLE && job_valid && !stall;

    // New schedule word from the finished SubWord.
    always_comb
    begin
        logic [31:0] t;
        t = {tw_reg[23:0], sb_out};
        if (wi_reg[2:0] == 3'd0 || (!aes256_reg && wi_reg[1:0] == 2'd0))
            t[31:24] = t[31:24] ^ rc_reg;
        new_w = old_w ^ t;
    end

    // Sequencer: key stream, key expansion, rounds, flush.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pf_reg <= '0;
        end
        else if (!stall)
        begin
            if (wb_valid)
            begin
                if (pf_reg == FillW'(OUTPUT_BYTES - 1))
                    pf_reg <= '0;
                else
                    pf_reg <= pf_reg + 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                        state_reg <= S_KEY;
                end
                S_KEY:
                begin
                    if (kleft_reg == 6'd1)
                        state_reg <= S_SCH;
                end
                S_SCH:
                begin
                    if (wi_reg == total - 6'd1 &&
                        !((wi_reg[2:0] == 3'd0 || wi_reg[1:0] == 2'd0) && sb_reg != 2'd3))
                        state_reg <= S_RND;
                end
                S_RND:
                begin
                    if (kb_reg == 4'd15 && rnd_reg == nr)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= S_IDLE;
                    pf_reg <= '0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Data registers of the sequencer.
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            if (wb_valid)
            begin
                if (pf_reg == '0)
                    pb_reg <= {wb, 56'd0};
                else
                    pb_reg[8'(63 - 8 * 32'(pf_reg)) -: 8] <= wb;
            end
            case (state_reg)
                S_IDLE:
                begin
                    kin_reg <= job.key;
                    aes256_reg <= job.aes256;
                    kleft_reg <= job.aes256 ? 6'd32 : 6'd16;
                    st_reg <= job.pt ^ job.key[255:128];
                    wi_reg <= job.aes256 ? 6'd8 : 6'd4;
                    kwin_reg <= job.key;
                    rkeys_reg[0] <= job.key[255:128];
                    rkeys_reg[1] <= job.key[127:0];
                    sb_reg <= 2'd0;
                    rc_reg <= 8'h01;
                    rnd_reg <= 4'd1;
                    kb_reg <= 4'd0;
                end
                S_KEY:
                begin
                    kin_reg <= {kin_reg[247:0], 8'h00};
                    kleft_reg <= kleft_reg - 6'd1;
                end
                S_SCH:
                begin
                    if ((wi_reg[2:0] == 3'd0 || wi_reg[1:0] == 2'd0 && !aes256_reg ||
                         aes256_reg && wi_reg[2:0] == 3'd4) && sb_reg != 2'd3)
                    begin
                        tw_reg <= {tw_reg[23:0], sb_out};
                        sb_reg <= sb_reg + 2'd1;
                    end
                    else
                    begin
                        logic [31:0] nw;
                        if (wi_reg[2:0] == 3'd0 || wi_reg[1:0] == 2'd0 && !aes256_reg ||
                            aes256_reg && wi_reg[2:0] == 3'd4)
                        begin
                            nw = new_w;
                            if (wi_reg[2:0] == 3'd0 || (!aes256_reg && wi_reg[1:0] == 2'd0))
                                rc_reg <= xt(rc_reg);
                        end
                        else
                            nw = old_w ^ prev_w;
                        sb_reg <= 2'd0;
                        if (aes256_reg)
                            kwin_reg <= {kwin_reg[223:0], nw};
                        else
                            kwin_reg <= {kwin_reg[223:128], nw, 128'd0};
                        rkeys_reg[wi_reg[5:2]][8'(127 - 32 * 32'(wi_reg[1:0])) -: 32] <= nw;
                        wi_reg <= wi_reg + 6'd1;
                    end
                end
                S_RND:
                begin
                    kb_reg <= kb_reg + 4'd1;
                    if (kb_reg == 4'd15)
                    begin
                        rnd_reg <= rnd_reg + 4'd1;
                        if (rnd_reg == nr)
                            ct_reg <= sr_st ^ rk;
                        else
                            st_reg <= mc_st ^ rk;
                    end
                    else
                        st_reg <= sub_st;
                end
                default: ;
            endcase
        end
    end

    // Result queue; a word leaves when full or at the end of the block.
    logic push_w, fin_word;
    out_item_t ow;

    // A full word that closes the stream carries the ciphertext itself.
    assign fin_word = state_reg == S_RND && kb_reg == 4'd15 && rnd_reg == nr &&
                      pf_reg == FillW'(OUTPUT_BYTES - 1);

    always_comb
    begin
        push_w = !stall && ((wb_valid && pf_reg == FillW'(OUTPUT_BYTES - 1)) ||
                            (emit_last && pf_reg != '0) );
        ow.witness_word = pb_reg;
        ow.witness_bytes = 4'(pf_reg);
        ow.cipher_hi = 64'd0;
        ow.cipher_lo = 64'd0;
        ow.last = 1'b0;
        if (wb_valid)
        begin
            if (pf_reg == '0)
                ow.witness_word = {wb, 56'd0};
            else
                ow.witness_word[8'(63 - 8 * 32'(pf_reg)) -: 8] = wb;
            ow.witness_bytes = 4'(OUTPUT_BYTES);
        end
        if (emit_last)
        begin
            ow.cipher_hi = ct_reg[127:64];
            ow.cipher_lo = ct_reg[63:0];
            ow.last = 1'b1;
        end
        else if (fin_word)
        begin
            ow.cipher_hi = sr_st[127:64] ^ rk[127:64];
            ow.cipher_lo = sr_st[63:0] ^ rk[63:0];
            ow.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= 3'd0;
            owp_reg <= 2'd0;
            orp_reg <= 2'd0;
        end
        else
        begin
            if (push_w)
                owp_reg <= owp_reg + 2'd1;
            if (pop && !empty)
                orp_reg <= orp_reg + 2'd1;
            ocnt_reg <= ocnt_reg + {2'd0, push_w} - {2'd0, pop && !empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_w)
            oq_reg[owp_reg] <= ow;
    end

    assign empty = ocnt_reg == 3'd0;
    assign out_item = oq_reg[orp_reg];

    assert property (@(posedge clk) disable iff (!rst_n) ocnt_reg <= 3'd4)
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> state_reg == S_IDLE)
        else $error("job taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !stall) |=> state_reg == S_IDLE)
        else $error("flush did not return to idle");
endmodule

@@ dv/aes_encrypt_inverse_trace_tb.sv @@
module aes_encrypt_inverse_trace_tb;
    import aet_pkg::*;

    localparam int NumRandom = 101;
    localparam int DrainCycles = 500;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_data;
    logic       push;
    logic       full;
    in_item_t   in_item;
    logic       empty;
    logic       pop;
    out_item_t  out_item;

    // Expected results, oldest first.
    out_item_t  expected_q[$];
    int         fail_count;
    bit         quiet_phase;
    bit         hold_pop;
    logic       key256;

    aes_encrypt_inverse_trace u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // GF(2^8) arithmetic for the encryption predictor.
    function automatic logic [7:0] dbl(input logic [7:0] a);
        dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ a;
            a = dbl(a);
        end
        fmul = r;
    endfunction

    function automatic logic [7:0] finv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] p;
        int         e;
        r = 8'h01;
        p = x;
        e = 254;
        while (e != 0)
        begin
            if (e[0])
                r = fmul(r, p);
            p = fmul(p, p);
            e = e >> 1;
        end
        finv = (x == 8'h00) ? 8'h00 : r;
    endfunction

    function automatic logic [7:0] sub_affine(input logic [7:0] t);
        logic [7:0] rows [8];
        logic [7:0] res;
        rows = '{8'hF1, 8'hE3, 8'hC7, 8'h8F, 8'h1F, 8'h3E, 8'h7C, 8'hF8};
        for (int i = 0; i < 8; i++)
            res[i] = ^(rows[i] & t);
        sub_affine = res ^ 8'h63;
    endfunction

    // Encrypt one block, collecting the witness stream and queuing the words.
    task automatic predict_encryption(input in_item_t it, input logic wide);
        logic [7:0]  key [32];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  w [60][4];
        logic [7:0]  t [4];
        logic [7:0]  rot [4];
        logic [7:0]  wit [$];
        logic [7:0]  rc;
        logic [7:0]  a0, a1, a2, a3;
        logic [255:0] kv;
        logic [127:0] pv;
        out_item_t   o;
        int          nk, nr, total, cnt;
        kv = {it.key_word0, it.key_word1, it.key_word2, it.key_word3};
        pv = {it.plaintext_hi, it.plaintext_lo};
        nk = wide ? 8 : 4;
        nr = wide ? 14 : 10;
        total = 4 * (nr + 1);
        rc = 8'h01;
        for (int i = 0; i < 32; i++)
            key[i] = kv[255 - 8 * i -: 8];
        for (int i = 0; i < 16; i++)
            st[i] = pv[127 - 8 * i -: 8];
        for (int i = 0; i < 4 * nk; i++)
            wit.push_back(key[i]);
        for (int i = 0; i < nk; i++)
            for (int b = 0; b < 4; b++)
                w[i][b] = key[4 * i + b];
        for (int i = nk; i < total; i++)
        begin
            t = w[i - 1];
            if (i % nk == 0)
            begin
                rot = '{t[1], t[2], t[3], t[0]};
                for (int b = 0; b < 4; b++)
                begin
                    wit.push_back(finv(rot[b]));
                    t[b] = sub_affine(finv(rot[b]));
                end
                t[0] = t[0] ^ rc;
                rc = dbl(rc);
            end
            else if (nk > 6 && i % nk == 4)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    wit.push_back(finv(t[b]));
                    t[b] = sub_affine(finv(t[b]));
                end
            end
            for (int b = 0; b < 4; b++)
                w[i][b] = w[i - nk][b] ^ t[b];
        end
        for (int k = 0; k < 16; k++)
            st[k] = st[k] ^ w[k / 4][k % 4];
        for (int r = 1; r <= nr; r++)
        begin
            for (int k = 0; k < 16; k++)
            begin
                wit.push_back(finv(st[k]));
                st[k] = sub_affine(finv(st[k]));
            end
            // Row shift: byte (row, col) takes byte (row, col + row).
            for (int k = 0; k < 16; k++)
                tmp[k] = st[(k % 4) + 4 * (((k / 4) + (k % 4)) % 4)];
            st = tmp;
            if (r != nr)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[4 * c];
                    a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2];
                    a3 = st[4 * c + 3];
                    st[4 * c]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    st[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    st[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    st[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            for (int k = 0; k < 16; k++)
                st[k] = st[k] ^ w[4 * r + k / 4][k % 4];
        end
        // Pack the witness stream eight bytes per word.
        for (int pos = 0; pos < wit.size(); pos += 8)
        begin
            cnt = wit.size() - pos;
            if (cnt > 8)
                cnt = 8;
            o = '0;
            for (int j = 0; j < cnt; j++)
                o.witness_word[63 - 8 * j -: 8] = wit[pos + j];
            o.witness_bytes = 4'(cnt);
            o.last = (pos + cnt >= wit.size());
            if (o.last)
                for (int j = 0; j < 8; j++)
                begin
                    o.cipher_hi[63 - 8 * j -: 8] = st[j];
                    o.cipher_lo[63 - 8 * j -: 8] = st[8 + j];
                end
            expected_q.push_back(o);
        end
    endtask

    // Offer one transaction with random idle bursts; predict when accepted.
    // Push stays high afterward so the next transaction can follow directly.
    task automatic send_block(input in_item_t it);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_encryption(it, key256);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic set_key_size(input logic v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        key256 = v;
    endtask

    function automatic in_item_t rand_block();
        in_item_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        rand_block = it;
    endfunction

    // Result side: random stalls, one long hold-off, field checks.
    initial
    begin
        out_item_t exp_item;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pop)
            begin
                pop <= 1'b0;
                repeat (400) @(negedge clk);
                hold_pop = 1'b0;
            end
            if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            if (!empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected transaction: witness_word %h", out_item.witness_word);
                    fail_count++;
                end
                else
                begin
                    exp_item = expected_q.pop_front();
                    if (out_item.witness_word !== exp_item.witness_word)
                    begin
                        $error("witness_word expected %h actual %h",
                               exp_item.witness_word, out_item.witness_word);
                        fail_count++;
                    end
                    if (out_item.witness_bytes !== exp_item.witness_bytes)
                    begin
                        $error("witness_bytes expected %0d actual %0d",
                               exp_item.witness_bytes, out_item.witness_bytes);
                        fail_count++;
                    end
                    if (out_item.cipher_hi !== exp_item.cipher_hi)
                    begin
                        $error("cipher_hi expected %h actual %h",
                               exp_item.cipher_hi, out_item.cipher_hi);
                        fail_count++;
                    end
                    if (out_item.cipher_lo !== exp_item.cipher_lo)
                    begin
                        $error("cipher_lo expected %h actual %h",
                               exp_item.cipher_lo, out_item.cipher_lo);
                        fail_count++;
                    end
                    if (out_item.last !== exp_item.last)
                    begin
                        $error("last expected %0d actual %0d", exp_item.last, out_item.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stimulus: directed table, then random blocks across key sizes.
    initial
    begin
        typedef struct {
            logic     wide;
            in_item_t it;
        } dir_row_t;
        dir_row_t rows [$];
        dir_row_t row;
        in_item_t it;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        push = 1'b0;
        in_item = '0;
        fail_count = 0;
        quiet_phase = 1'b0;
        hold_pop = 1'b0;
        key256 = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // FIPS-197 vectors, all-zero and all-ones blocks, ignored upper key words.
        rows.push_back('{1'b0, in_item_t'{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'h0, 64'h0, 64'h0011223344556677, 64'h8899aabbccddeeff}});
        rows.push_back('{1'b0, in_item_t'('0)});
        rows.push_back('{1'b0, in_item_t'('1)});
        rows.push_back('{1'b0, in_item_t'{64'h0, 64'h0, 64'hffffffffffffffff,
            64'hffffffffffffffff, 64'h0, 64'h0}});
        rows.push_back('{1'b0, in_item_t'{64'hffffffffffffffff, 64'hffffffffffffffff,
            64'h0, 64'h0, 64'h0, 64'h0}});
        rows.push_back('{1'b1, in_item_t'{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'h1011121314151617, 64'h18191a1b1c1d1e1f,
            64'h0011223344556677, 64'h8899aabbccddeeff}});
        rows.push_back('{1'b1, in_item_t'('0)});
        rows.push_back('{1'b1, in_item_t'('1)});
        rows.push_back('{1'b1, in_item_t'{64'h0, 64'h0, 64'hffffffffffffffff, 64'h0,
            64'hffffffffffffffff, 64'h0}});

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.wide !== key256)
            begin
                wait_idle();
                set_key_size(row.wide);
            end
            send_block(row.it);
        end

        // Long hold-off on the result side while blocks keep coming.
        hold_pop = 1'b1;
        for (int n = 0; n < NumRandom; n++)
        begin
            if (n % 25 == 24)
            begin
                wait_idle();
                set_key_size(1'($urandom_range(0, 1)));
            end
            if (n >= NumRandom - 15)
                quiet_phase = 1'b1;
            it = rand_block();
            send_block(it);
        end
        wait_idle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: generous against ~110 blocks of up to 39 stalled results.
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
